[hdl/interval_nesting_depth_unit_defines.svh]
// ----------------------------------------------------------------------------
// Interval nesting depth unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_NESTING_DEPTH_UNIT_DEFINES_SVH
`define INTERVAL_NESTING_DEPTH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define IND_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define IND_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define IND_ASSERT(lbl, cond, msg)
`define IND_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hdl/ind_pkg.sv]
// ----------------------------------------------------------------------------
// Interval nesting depth package
// Sizes, command codes and the queued item type shared by all modules.
// ----------------------------------------------------------------------------
package ind_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = 6;
	localparam int TIME_W      = 64;
	localparam int DUR_W       = 48;
	localparam int SD_W        = 49;
	localparam int NUM_W       = 32;
	localparam int IN_DATA_W   = 112;
	localparam int OUT_DATA_W  = 96;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [TIME_W-1:0] start;
		logic [DUR_W-1:0]         dur;
		logic signed [TIME_W-1:0] fin;
	} ind_item_t;
endpackage

[hdl/ind_front.sv]
// ----------------------------------------------------------------------------
// Interval nesting depth front end
// Accepts input beats, forms the saturated end time and queues the item.
// ----------------------------------------------------------------------------
module ind_front
	import ind_pkg::*;
(
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // start_time[63:0], duration[111:64]
	input  logic                 s_axis_tuser,  // command
	input  logic                 queue_full,
	output logic                 push,
	output ind_item_t            item
);
	logic [TIME_W:0]          sum;
	logic signed [TIME_W-1:0] start;
	logic [DUR_W-1:0]         dur;

	assign start = s_axis_tdata[TIME_W-1:0];
	assign dur   = s_axis_tdata[TIME_W+DUR_W-1:TIME_W];
	assign sum   = {start[TIME_W-1], start} + {{(TIME_W+1-DUR_W){1'b0}}, dur};

	always_comb begin
		item.cmd   = s_axis_tuser;
		item.start = start;
		item.dur   = dur;
		// Duration is never negative, so only a positive overflow can occur.
		if (sum[TIME_W] != sum[TIME_W-1]) begin
			item.fin = {1'b0, {(TIME_W-1){1'b1}}};
		end else begin
			item.fin = sum[TIME_W-1:0];
		end
	end

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;
endmodule

[hdl/ind_queue.sv]
// ----------------------------------------------------------------------------
// Interval nesting depth queue
// Short FIFO that decouples the front end from the stack engine.
// ----------------------------------------------------------------------------
module ind_queue
	import ind_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ind_item_t push_item,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output ind_item_t head_item
);
	ind_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

[hdl/ind_back.sv]
// ----------------------------------------------------------------------------
// Interval nesting depth stack engine
// Pops finished intervals, finds the parent, pushes events, runs flushes and drives results.
// ----------------------------------------------------------------------------
module ind_back
	import ind_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ind_item_t             head_item,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // event_number, nesting_depth,
	                                              // self_duration, deepest_so_far
	output logic                  m_axis_tuser,  // overflow
	output logic                  m_axis_tlast,
	output logic [CNT_W-1:0]      stack_count
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POP   = 3'd1;
	localparam logic [2:0] ST_FIND  = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]               state_q;
	ind_item_t                cur_q;
	logic [NUM_W-1:0]         num_q;
	logic [NUM_W-1:0]         counter_q;
	logic [DEPTH_W-1:0]       mark_q;
	logic [CNT_W-1:0]         count_q;
	logic                     found_q;
	logic [IDX_W-1:0]         par_q;

	logic signed [TIME_W-1:0] end_q   [STACK_DEPTH];
	logic [DEPTH_W-1:0]       depth_q [STACK_DEPTH];
	logic [NUM_W-1:0]         numb_q  [STACK_DEPTH];
	logic signed [SD_W-1:0]   sd_q    [STACK_DEPTH];

	logic                     o_vld_q;
	logic [NUM_W-1:0]         o_num_q;
	logic [DEPTH_W-1:0]       o_depth_q;
	logic [SD_W-1:0]          o_sd_q;
	logic [DEPTH_W-1:0]       o_mark_q;
	logic                     o_ovf_q;
	logic                     o_last_q;

	logic                     slot_free;
	logic [IDX_W-1:0]         top_idx;
	logic [IDX_W-1:0]         next_idx;
	logic                     top_done;
	logic                     next_done;
	logic                     hit_found;
	logic [IDX_W-1:0]         hit_idx;
	logic [DEPTH_W-1:0]       new_depth;
	logic [DEPTH_W-1:0]       new_mark;
	logic signed [SD_W:0]     diff;
	logic [SD_W-1:0]          par_sd;
	logic                     full_stack;
	logic                     emit;

	assign slot_free  = !o_vld_q || m_axis_tready;
	assign top_idx    = IDX_W'(count_q - 1'b1);
	assign next_idx   = IDX_W'(count_q - 2'd2);
	assign top_done   = (count_q != '0) && (end_q[top_idx] <= cur_q.start);
	assign next_done  = (count_q > CNT_W'(1)) && (end_q[next_idx] <= cur_q.start);
	assign full_stack = (count_q == CNT_W'(STACK_DEPTH));

	// Deepest open entry whose end covers the new end.
	always_comb begin
		hit_found = 1'b0;
		hit_idx   = '0;
		for (int j = 0; j < STACK_DEPTH; j++) begin
			if ((CNT_W'(j) < count_q) && (end_q[j] >= cur_q.fin)) begin
				hit_found = 1'b1;
				hit_idx   = IDX_W'(j);
			end
		end
	end

	assign new_depth = found_q ? depth_q[par_q] + 1'b1 : '0;
	assign new_mark  = (new_depth > mark_q) ? new_depth : mark_q;
	assign diff      = {sd_q[par_q][SD_W-1], sd_q[par_q]} - {2'b00, cur_q.dur};
	// Only the low side can saturate since a duration is never negative.
	assign par_sd    = (diff[SD_W] != diff[SD_W-1]) ? {1'b1, {(SD_W-1){1'b0}}}
	                                               : diff[SD_W-1:0];

	always_comb begin
		emit = 1'b0;
		unique case (state_q)
			ST_POP:   emit = top_done && slot_free;
			ST_APPLY: emit = full_stack && slot_free;
			ST_FLUSH: emit = slot_free;
			default:  emit = 1'b0;
		endcase
	end

	assign pop = (state_q == ST_IDLE) && head_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_item;
		end
		if (state_q == ST_FIND) begin
			found_q <= hit_found;
			par_q   <= hit_idx;
		end
		if (state_q == ST_APPLY && (!full_stack || slot_free)) begin
			if (found_q) begin
				sd_q[par_q] <= par_sd;
			end
			if (!full_stack) begin
				end_q[count_q[IDX_W-1:0]]   <= cur_q.fin;
				depth_q[count_q[IDX_W-1:0]] <= new_depth;
				numb_q[count_q[IDX_W-1:0]]  <= num_q;
				sd_q[count_q[IDX_W-1:0]]    <= {1'b0, cur_q.dur};
			end
		end
		if (emit) begin
			if (state_q == ST_APPLY) begin
				o_num_q   <= num_q;
				o_depth_q <= new_depth;
				o_sd_q    <= {1'b0, cur_q.dur};
				o_mark_q  <= new_mark;
				o_ovf_q   <= 1'b1;
				o_last_q  <= 1'b1;
			end else begin
				o_num_q   <= numb_q[top_idx];
				o_depth_q <= depth_q[top_idx];
				o_sd_q    <= sd_q[top_idx];
				o_mark_q  <= mark_q;
				o_ovf_q   <= 1'b0;
				o_last_q  <= (state_q == ST_FLUSH) ? (count_q == CNT_W'(1)) : !next_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			num_q     <= '0;
			counter_q <= '0;
			mark_q    <= '0;
			count_q   <= '0;
			o_vld_q   <= 1'b0;
		end else begin
			if (emit) begin
				o_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				o_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head_item.cmd == CMD_FLUSH) begin
							if (count_q != '0) begin
								state_q <= ST_FLUSH;
							end else begin
								counter_q <= '0;
								mark_q    <= '0;
							end
						end else begin
							num_q     <= counter_q;
							counter_q <= counter_q + 1'b1;
							state_q   <= ST_POP;
						end
					end
				end
				ST_POP: begin
					if (!top_done) begin
						state_q <= ST_FIND;
					end else if (slot_free) begin
						count_q <= count_q - 1'b1;
					end
				end
				ST_FIND: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (!full_stack || slot_free) begin
						mark_q  <= new_mark;
						state_q <= ST_IDLE;
						if (!full_stack) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						count_q <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							counter_q <= '0;
							mark_q    <= '0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = o_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - NUM_W - 2*DEPTH_W - SD_W){1'b0}},
	                        o_mark_q, o_sd_q, o_depth_q, o_num_q};
	assign m_axis_tuser  = o_ovf_q;
	assign m_axis_tlast  = o_last_q;
	assign stack_count   = count_q;
endmodule

[hdl/interval_nesting_depth_unit.sv]
// ----------------------------------------------------------------------------
// Interval nesting depth unit
// Nesting depth and self duration of one track's sorted timed events.
// ----------------------------------------------------------------------------
// Events queue in a two-beat FIFO behind the input and are then handled one at
// a time by the stack engine: an event goes through take, pop check (repeated
// for each finished interval it pops), parent search and push, and a flush pops
// the open entries one by one. The parent search compares all STACK_DEPTH open
// ends in parallel. One result beat leaves per cycle at most, through a single
// output register, and the engine waits while it is full.
`include "interval_nesting_depth_unit_defines.svh"
module interval_nesting_depth_unit
	import ind_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // start_time[63:0], duration[111:64]
	input  logic                  s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // event_number[31:0], nesting_depth[37:32],
	                                              // self_duration[86:38], deepest_so_far[92:87]
	output logic                  m_axis_tuser,  // overflow
	output logic                  m_axis_tlast
);
	logic             push;
	ind_item_t        push_item;
	logic             queue_full;
	logic             head_valid;
	ind_item_t        head_item;
	logic             pop;
	logic [CNT_W-1:0] stack_count;

	ind_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (queue_full),
		.push          (push),
		.item          (push_item)
	);

	ind_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ind_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.stack_count   (stack_count)
	);

	`IND_ASSERT(a_count_range, stack_count <= CNT_W'(STACK_DEPTH), "stack count above depth")
	`IND_ASSERT(a_ovf_last, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast, "overflow beat not last")
	`IND_ASSERT_NEXT(a_pop_empty, pop && stack_count == '0 && head_item.cmd == CMD_FLUSH, stack_count == '0, "empty flush changed stack")
endmodule

[tb/tb_interval_nesting_depth_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval nesting depth unit testbench
// Sorted event tracks with random nesting go in; a predictor with its own
// interval stack computes the expected results, and a scoreboard compares them.
// ----------------------------------------------------------------------------
module tb_interval_nesting_depth_unit;
	import ind_pkg::*;

	typedef struct {
		logic [NUM_W-1:0]   number;
		logic [DEPTH_W-1:0] depth;
		logic [SD_W-1:0]    self_dur;
		logic [DEPTH_W-1:0] deepest;
		logic               ovf;
		logic               lst;
	} span_result_t;

	class nesting_scoreboard;
		longint         span_end[STACK_DEPTH];
		int             span_depth[STACK_DEPTH];
		int unsigned    span_number[STACK_DEPTH];
		longint         span_self[STACK_DEPTH];
		int             open_spans;
		int unsigned    arrivals;
		int             deepest;
		span_result_t   pending[$];
		int             errors;
		int             checked;
		int             overflows;

		function void clear();
			open_spans = 0;
			arrivals = 0;
			deepest = 0;
			errors = 0;
			checked = 0;
			overflows = 0;
		endfunction

		function void push_result(int unsigned num, int dep, longint self_dur, bit ovf);
			span_result_t r;
			r.number = num;
			r.depth = dep[DEPTH_W-1:0];
			r.self_dur = self_dur[SD_W-1:0];
			r.deepest = deepest[DEPTH_W-1:0];
			r.ovf = ovf;
			r.lst = 1'b0;
			pending.push_back(r);
		endfunction

		function void pop_top();
			open_spans--;
			push_result(span_number[open_spans], span_depth[open_spans],
				span_self[open_spans], 1'b0);
		endfunction

		function void note_input(logic cmd, logic signed [TIME_W-1:0] start,
			logic [DUR_W-1:0] dur);
			int     prior_size;
			longint fin;
			longint d;
			longint s;
			int     dep;
			int unsigned num;
			prior_size = pending.size();
			if (cmd == CMD_FLUSH) begin
				while (open_spans > 0)
					pop_top();
				arrivals = 0;
				deepest = 0;
			end else begin
				s = start;
				d = longint'({16'd0, dur});
				fin = (s > 64'sh7FFFFFFFFFFFFFFF - d) ? 64'sh7FFFFFFFFFFFFFFF : s + d;
				num = arrivals;
				arrivals++;
				dep = 0;
				while (open_spans > 0 && span_end[open_spans-1] <= s)
					pop_top();
				for (int j = open_spans; j > 0; j--) begin
					if (span_end[j-1] >= fin) begin
						dep = span_depth[j-1] + 1;
						span_self[j-1] -= d;
						if (span_self[j-1] < -(64'sd1 <<< 48))
							span_self[j-1] = -(64'sd1 <<< 48);
						break;
					end
				end
				if (dep > deepest)
					deepest = dep;
				if (open_spans >= STACK_DEPTH) begin
					push_result(num, dep, d, 1'b1);
					overflows++;
				end else begin
					span_end[open_spans] = fin;
					span_depth[open_spans] = dep;
					span_number[open_spans] = num;
					span_self[open_spans] = d;
					open_spans++;
				end
			end
			if (pending.size() > prior_size)
				pending[$].lst = 1'b1;
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic ovf, logic lst);
			span_result_t e;
			if (pending.size() == 0) begin
				$error("Result beat with nothing expected: %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (data[31:0] !== e.number) begin
				$error("event_number: expected %0d, got %0d", e.number, data[31:0]);
				errors++;
			end
			if (data[37:32] !== e.depth) begin
				$error("nesting_depth: expected %0d, got %0d", e.depth, data[37:32]);
				errors++;
			end
			if (data[86:38] !== e.self_dur) begin
				$error("self_duration: expected %h, got %h", e.self_dur, data[86:38]);
				errors++;
			end
			if (data[92:87] !== e.deepest) begin
				$error("deepest_so_far: expected %0d, got %0d", e.deepest, data[92:87]);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0b, got %0b", e.ovf, ovf);
				errors++;
			end
			if (lst !== e.lst) begin
				$error("last: expected %0b, got %0b", e.lst, lst);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	nesting_scoreboard sb = new();
	int unsigned cycles = 0;
	int          beats_sent = 0;
	int          flushes = 0;
	bit          stall_enable = 1'b1;
	longint      track_time;

	interval_nesting_depth_unit u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// Sink: check every accepted result beat; stall in a pattern of its own.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	always @(negedge clk) begin
		if (!stall_enable)
			m_axis_tready <= 1'b1;
		else if (cycles[7:6] == 2'b11)
			m_axis_tready <= ($urandom_range(0, 9) == 0);
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	// Drive one beat, holding it until the handshake, with an occasional random gap first.
	// Valid stays high between beats of a burst and drops only for a gap.
	task automatic send_beat(logic cmd, logic [63:0] start, logic [DUR_W-1:0] dur);
		if (beats_sent % 8 == 0 && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {dur, start};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(cmd, start, dur);
		beats_sent++;
		if (cmd == CMD_FLUSH)
			flushes++;
		@(negedge clk);
	endtask

	task automatic send_event(logic [63:0] start, logic [DUR_W-1:0] dur);
		send_beat(CMD_EVENT, start, dur);
	endtask

	// A well-formed track: starts ascend, children mostly fit inside parents.
	task automatic send_track(int count, bit deep);
		longint d;
		for (int i = 0; i < count; i++) begin
			track_time += longint'($urandom_range(0, deep ? 2 : 40));
			d = deep ? longint'(1000 - i) : longint'($urandom_range(0, 60));
			if ($urandom_range(0, 15) == 0)
				d = {$urandom, $urandom} & 48'hFFFFFFFFFFFF;
			send_event(track_time, d[DUR_W-1:0]);
		end
		if ($urandom_range(0, 3) != 0)
			send_beat(CMD_FLUSH, {$urandom, $urandom}, DUR_W'($urandom));
	endtask

	initial begin
		sb.clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty flush, extremes of time and duration, saturation.
		send_beat(CMD_FLUSH, '1, '1);
		send_event(64'h8000000000000000, 48'hFFFFFFFFFFFF);
		send_event(64'h8000000000000000, 48'h0);
		send_event(64'h8000000000000001, 48'h5);
		send_event(64'h7FFFFFFFFFFFFFF0, 48'hFFFFFFFFFFFF);
		send_event(64'h7FFFFFFFFFFFFFF0, 48'hFFFFFFFFFFFF);
		send_event(64'h7FFFFFFFFFFFFFF0, 48'hFFFFFFFFFFFF);
		send_event(64'h7FFFFFFFFFFFFFFF, 48'h0);
		send_beat(CMD_FLUSH, '0, '0);
		send_event(64'h0, 48'd10);
		send_event(64'h10, 48'd3);
		send_beat(CMD_FLUSH, 64'h5555555555555555, 48'hAAAAAAAAAAAA);
		// Full stack: a deep chain overflows and pops back out.
		track_time = -100;
		send_track(STACK_DEPTH + 3, 1'b1);
		send_event(64'h7000000000000000, 48'd1);
		send_beat(CMD_FLUSH, '0, '0);

		track_time = longint'($urandom);
		while (beats_sent < 370) begin
			stall_enable = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9))
				0: send_track(STACK_DEPTH + $urandom_range(0, 4), 1'b1);
				1: send_beat(1'($urandom_range(0, 1)), {$urandom, $urandom},
					DUR_W'({$urandom, $urandom}));
				default: send_track($urandom_range(1, 20), 1'b0);
			endcase
			if ($urandom_range(0, 7) == 0)
				track_time = {$urandom, $urandom};
		end
		send_beat(CMD_FLUSH, '0, '0);
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.errors++;
		$display("Sent %0d beats with %0d flushes; checked %0d results, %0d overflows.",
			beats_sent, flushes, sb.checked, sb.overflows);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hdl
hdl/ind_pkg.sv
hdl/ind_front.sv
hdl/ind_queue.sv
hdl/ind_back.sv
hdl/interval_nesting_depth_unit.sv
tb/tb_interval_nesting_depth_unit.sv
